// ----- sv/bmts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmts_pkg
// Shared widths, register indexes, command and status types of the modular
// trigger sequencer.
// ----------------------------------------------------------------------------
package bmts_pkg;

  localparam int ROWS_DEF    = 32;
  localparam int COLUMNS_DEF = 4;

  localparam int CFG_W      = 6;
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 15;
  localparam int PITCH_W    = 14;
  localparam int REM_W      = 5;
  localparam int DIV_W      = 6;
  localparam int GATES_W    = 6;
  localparam int COLPOS_W   = 2;
  localparam int STEPPOS_W  = 5;
  localparam int PROD1_W    = 12;
  localparam int DVD_W      = 19;
  localparam int DVS_W      = 16;

  localparam int DIV_MAX     = 32;
  localparam int PITCH_SCALE = 10000;

  localparam logic [IDX_W-1:0] REG_STEP_LENGTH   = 8'd0;
  localparam logic [IDX_W-1:0] REG_DIVISOR_ONE   = 8'd1;
  localparam logic [IDX_W-1:0] REG_DIVISOR_TWO   = 8'd2;
  localparam logic [IDX_W-1:0] REG_DIVISOR_THREE = 8'd3;

  localparam logic [CFG_W-1:0] STEP_LENGTH_RST = 6'd16;
  localparam logic [CFG_W-1:0] DIVISOR_RST     = 6'd4;

  typedef enum logic [2:0] {
    OP_STEP  = 3'd0,
    OP_MOD   = 3'd2,
    OP_REM   = 3'd3,
    OP_PITCH = 3'd4
  } div_op_t;

  typedef struct packed {
    logic      in_ready;
    logic      accept;
    logic      prod2;
    logic      div_start;
    logic      cap;
    div_op_t   div_op;
    logic [1:0] chan;
    logic      col_step;
    logic      rd_a;
    logic      rd_b;
    logic      rd_val;
    logic      cap_a;
    logic      cap_b;
    logic      cap_val;
    logic      wr_ins;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic falling;
    logic pitch_take;
    logic div_busy;
    logic adv_zero;
    logic out_free;
  } status_t;

  function automatic logic [DIV_W-1:0] clamp_div(input logic [CFG_W-1:0] v);
    logic [DIV_W-1:0] r;
    if (v == '0) begin
      r = DIV_W'(1);
    end else if (int'(v) > DIV_MAX) begin
      r = DIV_W'(DIV_MAX);
    end else begin
      r = DIV_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- sv/bmts_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmts_if
// Valid/ready channels: configuration writes, sample ticks and results.
// ----------------------------------------------------------------------------
interface bmts_cfg_if;
  import bmts_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface bmts_in_if;
  logic valid;
  logic ready;
  logic clock_gate;
  logic insert_request;
  logic freeze;
  modport source(output valid, clock_gate, insert_request, freeze, input ready);
  modport sink(input valid, clock_gate, insert_request, freeze, output ready);
endinterface

interface bmts_out_if;
  import bmts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VAL_W-1:0]     cell_value;
  logic                 trig_one;
  logic                 trig_two;
  logic                 trig_three;
  logic [GATES_W-1:0]   remainder_gates;
  logic [PITCH_W-1:0]   pitch_one_mv;
  logic [PITCH_W-1:0]   pitch_two_mv;
  logic [PITCH_W-1:0]   pitch_three_mv;
  logic [COLPOS_W-1:0]  column_pos;
  logic [STEPPOS_W-1:0] step_pos;
  modport source(output valid, cell_value, trig_one, trig_two, trig_three,
                 remainder_gates, pitch_one_mv, pitch_two_mv, pitch_three_mv,
                 column_pos, step_pos, input ready);
  modport sink(input valid, cell_value, trig_one, trig_two, trig_three,
               remainder_gates, pitch_one_mv, pitch_two_mv, pitch_three_mv,
               column_pos, step_pos, output ready);
endinterface

// ----- sv/bmts_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmts_div
// Restoring divider, one quotient bit per cycle, gives quotient and remainder.
// ----------------------------------------------------------------------------
module bmts_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bmts_pkg::DVD_W-1:0]  dividend,
  input  logic [bmts_pkg::DVS_W-1:0]  divisor,
  output logic                        busy,
  output logic [bmts_pkg::DVD_W-1:0]  quotient,
  output logic [bmts_pkg::DVS_W-1:0]  remainder
);
  import bmts_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dsr;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             take;

  assign shifted = {remainder, quotient[DVD_W-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign take    = ~trial[DVS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      remainder <= take ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quotient  <= {quotient[DVD_W-2:0], take};
    end
  end

endmodule

// ----- sv/bmts_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmts_mem
// Cell grid memory with per-entry valid bits; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module bmts_mem #(
  parameter int ROWS    = bmts_pkg::ROWS_DEF,
  parameter int COLUMNS = bmts_pkg::COLUMNS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [$clog2(COLUMNS*ROWS)-1:0]       rd_addr,
  output logic [bmts_pkg::VAL_W-1:0]            rd_data,
  input  logic                                  wr_en,
  input  logic [$clog2(COLUMNS*ROWS)-1:0]       wr_addr,
  input  logic [bmts_pkg::VAL_W-1:0]            wr_data,
  input  logic                                  clr_en,
  input  logic [$clog2(COLUMNS)-1:0]            clr_col,
  input  logic [$clog2(ROWS+1)-1:0]             clr_len
);
  import bmts_pkg::*;

  localparam int NE = COLUMNS * ROWS;
  localparam int AW = $clog2(NE);
  localparam int LW = $clog2(ROWS + 1);

  logic [VAL_W-1:0] mem [NE];
  logic [NE-1:0]    valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      // drop the tail of the column beyond the step length
      if (clr_en) begin
        for (int r = 0; r < ROWS; r++) begin
          if (LW'(r) >= clr_len) begin
            valid[AW'(clr_col) * AW'(ROWS) + AW'(r)] <= 1'b0;
          end
        end
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ----- sv/bmts_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmts_dp
// Datapath: configuration registers, step and column state, grid, shared
// divider, remainders, held pitches and the result register.
// ----------------------------------------------------------------------------
module bmts_dp #(
  parameter int ROWS    = bmts_pkg::ROWS_DEF,
  parameter int COLUMNS = bmts_pkg::COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bmts_pkg::cmd_t                  cmd,
  output bmts_pkg::status_t               st,
  input  logic                            cfg_valid,
  input  logic [bmts_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bmts_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  input  logic                            clock_gate,
  input  logic                            insert_request,
  input  logic                            freeze,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [bmts_pkg::VAL_W-1:0]      cell_value,
  output logic                            trig_one,
  output logic                            trig_two,
  output logic                            trig_three,
  output logic [bmts_pkg::GATES_W-1:0]    remainder_gates,
  output logic [bmts_pkg::PITCH_W-1:0]    pitch_one_mv,
  output logic [bmts_pkg::PITCH_W-1:0]    pitch_two_mv,
  output logic [bmts_pkg::PITCH_W-1:0]    pitch_three_mv,
  output logic [bmts_pkg::COLPOS_W-1:0]   column_pos,
  output logic [bmts_pkg::STEPPOS_W-1:0]  step_pos
);
  import bmts_pkg::*;

  localparam int SW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int LW = $clog2(ROWS + 1);
  localparam int AW = $clog2(COLUMNS * ROWS);

  logic [CFG_W-1:0]   step_length, divisor_one, divisor_two, divisor_three;
  logic [LW-1:0]      len;
  logic [DIV_W-1:0]   dcl [3];
  logic [SW-1:0]      step_index;
  logic [CW-1:0]      column_index, prev_col;
  logic               last_hi, last_lo;
  logic               gate, ins, frz, rising, falling;
  logic [LW-1:0]      adv;
  logic [PROD1_W-1:0] p1;
  logic [DVS_W-1:0]   prod;
  logic [VAL_W-1:0]   sum_a, sum_b, cell_val;
  logic [REM_W-1:0]   rem [3];
  logic [PITCH_W-1:0] held [3];
  logic [DVD_W-1:0]   dvd, div_quo;
  logic [DVS_W-1:0]   dsr, div_rem;
  logic               div_busy;
  logic               mod_wr;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VAL_W-1:0]   rd_data, wr_data;
  logic [GATES_W-1:0] gates_c;
  logic               trig3_c;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                             input logic [SW-1:0] r);
    return AW'(c) * AW'(ROWS) + AW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length   <= STEP_LENGTH_RST;
      divisor_one   <= DIVISOR_RST;
      divisor_two   <= DIVISOR_RST;
      divisor_three <= DIVISOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_LENGTH:   step_length   <= cfg_data;
        REG_DIVISOR_ONE:   divisor_one   <= cfg_data;
        REG_DIVISOR_TWO:   divisor_two   <= cfg_data;
        REG_DIVISOR_THREE: divisor_three <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (step_length == '0) begin
      len = LW'(1);
    end else if (int'(step_length) > ROWS) begin
      len = LW'(ROWS);
    end else begin
      len = LW'(step_length);
    end
    dcl[0] = clamp_div(divisor_one);
    dcl[1] = clamp_div(divisor_two);
    dcl[2] = clamp_div(divisor_three);
  end

  assign prev_col = (column_index == '0) ? CW'(COLUMNS - 1) : column_index - CW'(1);

  // divider operands
  always_comb begin
    case (cmd.div_op)
      OP_STEP: begin
        dvd = DVD_W'(step_index) + DVD_W'(1);
        dsr = DVS_W'(len);
      end
      OP_MOD: begin
        dvd = DVD_W'(sum_a) + DVD_W'(sum_b);
        dsr = prod;
      end
      OP_REM: begin
        dvd = DVD_W'(cell_val);
        dsr = DVS_W'(dcl[cmd.chan]);
      end
      OP_PITCH: begin
        dvd = DVD_W'(rem[cmd.chan] - REM_W'(1)) * DVD_W'(PITCH_SCALE);
        dsr = DVS_W'(dcl[cmd.chan]);
      end
      default: begin
        dvd = '0;
        dsr = DVS_W'(1);
      end
    endcase
  end

  bmts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dsr),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign mod_wr = cmd.cap && (cmd.div_op == OP_MOD);

  always_comb begin
    rd_en = cmd.rd_a | cmd.rd_b | cmd.rd_val;
    if (cmd.rd_a) begin
      rd_addr = cell_addr(prev_col, step_index);
    end else if (cmd.rd_b) begin
      rd_addr = cell_addr(prev_col, step_index - SW'(1));
    end else begin
      rd_addr = cell_addr(column_index, step_index);
    end
    wr_en   = mod_wr | (cmd.wr_ins & ins);
    wr_addr = cell_addr(column_index, step_index);
    wr_data = cmd.wr_ins ? VAL_W'(1) : div_rem[VAL_W-1:0];
  end

  bmts_mem #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .clr_en  (mod_wr),
    .clr_col (column_index),
    .clr_len (len)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_index   <= '0;
      column_index <= '0;
      last_hi      <= 1'b1;
      last_lo      <= 1'b1;
      held[0]      <= '0;
      held[1]      <= '0;
      held[2]      <= '0;
    end else begin
      if (cmd.accept) begin
        last_hi <= clock_gate;
        last_lo <= ~clock_gate;
      end
      // column moves one place per cycle while col_step is set, wrapping at the last column
      if (cmd.col_step) begin
        column_index <= (column_index == CW'(COLUMNS - 1)) ? '0 : column_index + CW'(1);
      end
      if (cmd.cap) begin
        case (cmd.div_op)
          OP_STEP:  step_index             <= SW'(div_rem);
          OP_PITCH: held[cmd.chan]         <= PITCH_W'(div_quo);
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      gate    <= clock_gate;
      ins     <= insert_request;
      frz     <= freeze;
      rising  <= clock_gate & ~last_hi;
      falling <= ~clock_gate & ~last_lo;
      p1      <= PROD1_W'(dcl[0]) * PROD1_W'(dcl[1]);
    end
    if (cmd.prod2) begin
      prod <= DVS_W'(DVD_W'(p1) * DVD_W'(dcl[2]));
    end
    if (cmd.cap && (cmd.div_op == OP_STEP)) begin
      adv <= frz ? '0 : LW'(div_quo);
    end else if (cmd.col_step) begin
      adv <= adv - LW'(1);
    end
    if (cmd.cap && (cmd.div_op == OP_REM)) begin
      rem[cmd.chan] <= REM_W'(div_rem);
    end
    if (cmd.cap_a) begin
      sum_a <= rd_data;
    end
    if (cmd.cap_b) begin
      sum_b <= (step_index == '0) ? '0 : rd_data;
    end
    if (cmd.cap_val) begin
      cell_val <= rd_data;
    end
  end

  always_comb begin
    trig3_c = gate && (rem[2] != '0);
    gates_c = '0;
    if (trig3_c && (rem[2] inside {[1:GATES_W]})) begin
      gates_c = GATES_W'(1) << (rem[2] - REM_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_value      <= cell_val;
      trig_one        <= gate && (rem[0] != '0);
      trig_two        <= gate && (rem[1] != '0);
      trig_three      <= trig3_c;
      remainder_gates <= gates_c;
      pitch_one_mv    <= held[0];
      pitch_two_mv    <= held[1];
      pitch_three_mv  <= held[2];
      column_pos      <= COLPOS_W'(column_index);
      step_pos        <= STEPPOS_W'(step_index);
    end
  end

  assign st.in_valid   = in_valid;
  assign st.falling    = falling;
  assign st.pitch_take = rising && (rem[cmd.chan] != '0);
  assign st.div_busy   = div_busy;
  assign st.adv_zero   = (adv == '0);
  assign st.out_free   = ~out_valid | out_ready;

endmodule

// ----- sv/bmts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmts_ctrl
// Sequencer for one tick: step and column update, grid update, remainders,
// pitch latches and result hand-off.
// ----------------------------------------------------------------------------
module bmts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  bmts_pkg::status_t   st,
  output bmts_pkg::cmd_t      cmd
);
  import bmts_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_PROD = 15'h0002,
    S_DIVS = 15'h0004,
    S_DIVC = 15'h0008,
    S_RDA  = 15'h0010,
    S_RDB  = 15'h0020,
    S_SUM  = 15'h0040,
    S_DIVM = 15'h0080,
    S_INS  = 15'h0100,
    S_RDV  = 15'h0200,
    S_VAL  = 15'h0400,
    S_REM  = 15'h0800,
    S_PIT  = 15'h1000,
    S_OUT  = 15'h2000,
    S_SPARE = 15'h4000
  } state_t;

  state_t     state, state_next;
  logic       launched, launched_next;
  logic [1:0] chan, chan_next;
  logic       finish;

  assign finish = launched && !st.div_busy;

  always_comb begin
    cmd           = '0;
    cmd.chan      = chan;
    cmd.in_ready  = (state == S_IDLE);
    state_next    = state;
    launched_next = launched;
    chan_next     = chan;
    // divide states launch, wait for the divider to go idle; S_PIT may skip
    if (!launched) begin
      launched_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (st.in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod2  = 1'b1;
        state_next = st.falling ? S_DIVS : S_INS;
      end
      S_DIVS, S_DIVM: begin
        cmd.div_op = (state == S_DIVS) ? OP_STEP : OP_MOD;
        if (!launched) begin
          cmd.div_start = 1'b1;
          launched_next = 1'b1;
        end else if (finish) begin
          cmd.cap       = 1'b1;
          launched_next = 1'b0;
          state_next    = (state == S_DIVS) ? S_DIVC : S_INS;
        end
      end
      S_DIVC: begin
        // one column per cycle until the advance count runs out
        if (st.adv_zero) begin
          state_next = S_RDA;
        end else begin
          cmd.col_step = 1'b1;
        end
      end
      S_RDA: begin
        cmd.rd_a   = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_b   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.cap_b  = 1'b1;
        state_next = S_DIVM;
      end
      S_INS: begin
        cmd.wr_ins = 1'b1;
        state_next = S_RDV;
      end
      S_RDV: begin
        cmd.rd_val = 1'b1;
        state_next = S_VAL;
      end
      S_VAL: begin
        cmd.cap_val = 1'b1;
        chan_next   = 2'd0;
        state_next  = S_REM;
      end
      S_REM: begin
        cmd.div_op = OP_REM;
        if (!launched) begin
          cmd.div_start = 1'b1;
          launched_next = 1'b1;
        end else if (finish) begin
          cmd.cap       = 1'b1;
          launched_next = 1'b0;
          if (chan == 2'd2) begin
            chan_next  = 2'd0;
            state_next = S_PIT;
          end else begin
            chan_next = chan + 2'd1;
          end
        end
      end
      S_PIT: begin
        cmd.div_op = OP_PITCH;
        if (!launched && !st.pitch_take) begin
          // zero remainder or no rising edge: pitch holds
          if (chan == 2'd2) begin
            chan_next  = 2'd0;
            state_next = S_OUT;
          end else begin
            chan_next = chan + 2'd1;
          end
        end else if (!launched) begin
          cmd.div_start = 1'b1;
          launched_next = 1'b1;
        end else if (finish) begin
          cmd.cap       = 1'b1;
          launched_next = 1'b0;
          if (chan == 2'd2) begin
            chan_next  = 2'd0;
            state_next = S_OUT;
          end else begin
            chan_next = chan + 2'd1;
          end
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next    = S_IDLE;
        launched_next = 1'b0;
        chan_next     = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
      chan     <= 2'd0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
      chan     <= chan_next;
    end
  end

endmodule

// ----- sv/binomial_mod_trigger_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_mod_trigger_sequencer_top
// Modular binomial-grid trigger sequencer, one result per sample tick.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (index 0 step length, 1..3 divisors), always
//            ready; write only while no tick is in flight.
//   item   : one beat per sample tick (clock level, insert, freeze).
//   result : one beat per tick: cell value, triggers, remainder gates, held
//            pitches in mV, column and step position.
//   While the clock level holds, a tick runs three remainder divisions from
//   accept to result. A rising edge adds a pitch division per channel with a
//   non-zero remainder. A falling edge adds the step division, the grid
//   reads and modulo division, plus a column step per column advanced (up to
//   32). Each division goes through one shared restoring divider.
//   A new tick is taken the cycle after the previous result is loaded.
//   The result register holds a beat until it is taken; while it is full the
//   sequencer finishes the next tick and then waits, so ticks are never lost.
//   Reset clears the grid (per-entry valid bits), step, column and pitches
//   at once, and restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module binomial_mod_trigger_sequencer_top #(
  parameter int ROWS    = bmts_pkg::ROWS_DEF,
  parameter int COLUMNS = bmts_pkg::COLUMNS_DEF
) (
  input logic         clk,
  input logic         rst,
  bmts_cfg_if.sink    cfg,
  bmts_in_if.sink     item,
  bmts_out_if.source  result
);
  import bmts_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg.ready  = 1'b1;
  assign item.ready = cmd.in_ready;

  bmts_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  bmts_dp #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .in_valid        (item.valid),
    .clock_gate      (item.clock_gate),
    .insert_request  (item.insert_request),
    .freeze          (item.freeze),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .cell_value      (result.cell_value),
    .trig_one        (result.trig_one),
    .trig_two        (result.trig_two),
    .trig_three      (result.trig_three),
    .remainder_gates (result.remainder_gates),
    .pitch_one_mv    (result.pitch_one_mv),
    .pitch_two_mv    (result.pitch_two_mv),
    .pitch_three_mv  (result.pitch_three_mv),
    .column_pos      (result.column_pos),
    .step_pos        (result.step_pos)
  );

endmodule

// ----- sv/bmts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmts_checker
// Port-level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
module bmts_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bmts_pkg::VAL_W-1:0]    cell_value,
  input logic                          trig_one,
  input logic                          trig_two,
  input logic                          trig_three,
  input logic [bmts_pkg::GATES_W-1:0]  remainder_gates
);
  import bmts_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_value))
    else $error("result beat dropped or changed while stalled");

  a_gates_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(remainder_gates))
    else $error("more than one remainder gate set");

  a_gates_trig: assert property (@(posedge clk) disable iff (rst)
    out_valid && (remainder_gates != '0) |-> trig_three)
    else $error("remainder gate without trigger three");

  a_zero_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cell_value == '0) |-> !trig_one && !trig_two && !trig_three)
    else $error("trigger fired on a zero cell");

endmodule

bind binomial_mod_trigger_sequencer_top bmts_checker u_bmts_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .cell_value      (result.cell_value),
  .trig_one        (result.trig_one),
  .trig_two        (result.trig_two),
  .trig_three      (result.trig_three),
  .remainder_gates (result.remainder_gates)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the modular trigger sequencer. Sample ticks are
// driven over the item channel and predicted by a behavioral copy of the grid,
// step, column and held pitches. Each result beat is compared field by field
// with the oldest prediction under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb;
  import bmts_pkg::*;

  localparam int NROW = ROWS_DEF;
  localparam int NCOL = COLUMNS_DEF;
  localparam int LIMIT_CYCLES = 3000000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 8'd9;

  typedef struct packed {
    logic [VAL_W-1:0]     cell_value;
    logic                 trig_one;
    logic                 trig_two;
    logic                 trig_three;
    logic [GATES_W-1:0]   remainder_gates;
    logic [PITCH_W-1:0]   pitch_one_mv;
    logic [PITCH_W-1:0]   pitch_two_mv;
    logic [PITCH_W-1:0]   pitch_three_mv;
    logic [COLPOS_W-1:0]  column_pos;
    logic [STEPPOS_W-1:0] step_pos;
  } tick_result_t;

  logic clk;
  logic rst;
  int   cycles;
  int   errors;
  int   send_idle_pct;
  int   stall_pct;
  logic gate_level;

  bmts_cfg_if cfg_ch();
  bmts_in_if  item_ch();
  bmts_out_if res_ch();

  binomial_mod_trigger_sequencer_top DUT (
    .clk(clk), .rst(rst), .cfg(cfg_ch), .item(item_ch), .result(res_ch)
  );

  // sequencer copy
  logic [CFG_W-1:0] reg_len, reg_d1, reg_d2, reg_d3;
  int               grid [NCOL*NROW];
  int               step_i, col_i;
  bit               last_hi, last_lo;
  int               pitch_held [3];
  tick_result_t     pending_results [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int clamp_val(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic model_reset();
    reg_len = STEP_LENGTH_RST;
    reg_d1 = DIVISOR_RST;
    reg_d2 = DIVISOR_RST;
    reg_d3 = DIVISOR_RST;
    foreach (grid[k]) grid[k] = 0;
    step_i = 0;
    col_i = 0;
    last_hi = 1'b1;
    last_lo = 1'b1;
    foreach (pitch_held[k]) pitch_held[k] = 0;
  endtask

  task automatic predict_tick(bit gate, bit ins, bit frz);
    int len, prod, val, s, adv, prev, sum, gates;
    int d [3];
    int rm [3];
    bit tr [3];
    bit rising, falling;
    tick_result_t r;
    len = clamp_val(reg_len, 1, NROW);
    d[0] = clamp_val(reg_d1, 1, DIV_MAX);
    d[1] = clamp_val(reg_d2, 1, DIV_MAX);
    d[2] = clamp_val(reg_d3, 1, DIV_MAX);
    prod = d[0] * d[1] * d[2];
    rising = gate && !last_hi;
    last_hi = gate;
    falling = !gate && !last_lo;
    last_lo = !gate;
    if (falling) begin
      s = step_i + 1;
      adv = frz ? 0 : s / len;
      col_i = (col_i + adv) % NCOL;
      step_i = s % len;
      prev = (col_i + NCOL - 1) % NCOL;
      sum = grid[prev*NROW + step_i];
      if (step_i != 0) sum += grid[prev*NROW + step_i - 1];
      grid[col_i*NROW + step_i] = sum % prod;
      for (int k = len; k < NROW; k++) grid[col_i*NROW + k] = 0;
    end
    if (ins) grid[col_i*NROW + step_i] = 1;
    val = grid[col_i*NROW + step_i];
    for (int k = 0; k < 3; k++) begin
      rm[k] = val % d[k];
      if (rising && rm[k] != 0) pitch_held[k] = (rm[k] - 1) * PITCH_SCALE / d[k];
      tr[k] = gate && (rm[k] != 0);
    end
    gates = (tr[2] && rm[2] >= 1 && rm[2] <= 6) ? (1 << (rm[2] - 1)) : 0;
    r.cell_value = val[VAL_W-1:0];
    r.trig_one = tr[0];
    r.trig_two = tr[1];
    r.trig_three = tr[2];
    r.remainder_gates = gates[GATES_W-1:0];
    r.pitch_one_mv = pitch_held[0][PITCH_W-1:0];
    r.pitch_two_mv = pitch_held[1][PITCH_W-1:0];
    r.pitch_three_mv = pitch_held[2][PITCH_W-1:0];
    r.column_pos = col_i[COLPOS_W-1:0];
    r.step_pos = step_i[STEPPOS_W-1:0];
    pending_results.push_back(r);
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (rst) res_ch.ready = 1'b0;
    else res_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    tick_result_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result beat, actual cell %0d", $time, res_ch.cell_value);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("cell_value", e.cell_value, res_ch.cell_value);
        check_field("trig_one", e.trig_one, res_ch.trig_one);
        check_field("trig_two", e.trig_two, res_ch.trig_two);
        check_field("trig_three", e.trig_three, res_ch.trig_three);
        check_field("remainder_gates", e.remainder_gates, res_ch.remainder_gates);
        check_field("pitch_one_mv", e.pitch_one_mv, res_ch.pitch_one_mv);
        check_field("pitch_two_mv", e.pitch_two_mv, res_ch.pitch_two_mv);
        check_field("pitch_three_mv", e.pitch_three_mv, res_ch.pitch_three_mv);
        check_field("column_pos", e.column_pos, res_ch.column_pos);
        check_field("step_pos", e.step_pos, res_ch.step_pos);
      end
    end
  end

  // called at a falling edge; returns at a falling edge after the beat
  task automatic send_tick(bit gate, bit ins, bit frz);
    if ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.clock_gate = gate;
    item_ch.insert_request = ins;
    item_ch.freeze = frz;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_tick(gate, ins, frz);
    @(negedge clk);
    item_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_STEP_LENGTH:   reg_len = val;
      REG_DIVISOR_ONE:   reg_d1 = val;
      REG_DIVISOR_TWO:   reg_d2 = val;
      REG_DIVISOR_THREE: reg_d3 = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_all(int len, int d1, int d2, int d3);
    write_reg(REG_STEP_LENGTH, CFG_W'(len));
    write_reg(REG_DIVISOR_ONE, CFG_W'(d1));
    write_reg(REG_DIVISOR_TWO, CFG_W'(d2));
    write_reg(REG_DIVISOR_THREE, CFG_W'(d3));
  endtask

  // mostly clean clock patterns, some noise on every field
  task automatic random_ticks(int n);
    bit ins, frz;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) gate_level = $urandom_range(1);
      else if ($urandom_range(2) == 0) gate_level = ~gate_level;
      ins = ($urandom_range(7) == 0);
      frz = ($urandom_range(5) == 0);
      send_tick(gate_level, ins, frz);
    end
  endtask

  task automatic test_directed();
    // defaults: seed the grid then clock it
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    // shorten length while step is past it
    write_reg(REG_STEP_LENGTH, 6'd2);
    for (int k = 0; k < 6; k++) send_tick(k[0], ~k[1], 1'b0);
    write_reg(REG_UNUSED, 6'd7);
    set_all(0, 0, 0, 0);
    for (int k = 0; k < 4; k++) send_tick(k[0], 1'b1, k[1]);
  endtask

  task automatic test_extremes();
    set_all(32, 32, 32, 32);
    random_ticks(120);
    set_all(63, 63, 63, 63);
    random_ticks(80);
    set_all(1, 1, 1, 1);
    random_ticks(60);
  endtask

  task automatic test_idle_mixes();
    int len_tab [4] = '{5, 3, 8, 16};
    int send_tab [4] = '{0, 55, 0, 35};
    int stall_tab [4] = '{0, 0, 55, 35};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_tab[p];
      stall_pct = stall_tab[p];
      set_all(len_tab[p], $urandom_range(2, 7), $urandom_range(2, 9), $urandom_range(2, 8));
      random_ticks(220);
      set_all($urandom_range(63), $urandom_range(63), $urandom_range(63), $urandom_range(63));
      random_ticks(200);
    end
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    gate_level = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    item_ch.valid = 1'b0;
    item_ch.clock_gate = 1'b0;
    item_ch.insert_request = 1'b0;
    item_ch.freeze = 1'b0;
    model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_extremes();
    test_idle_mixes();
    drain();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
